>>> sv/tma_pkg.sv
// Shared constants, types and helpers for the tile matrix multiply accumulator.
// Used by the top level, the accumulator cells and the port checker; no dependencies.
package tma_pkg;

    localparam int TILE          = 4;
    localparam int CELLS         = TILE * TILE;
    localparam int A_W           = 16;
    localparam int PROD_W        = 2 * A_W;
    localparam int SIZE_W        = 3;
    localparam int IDX_W         = 2;
    localparam int ACC_WIDTH_DEF = 48;

    // Slave-side tdata layout.
    localparam int A_LSB    = 0;
    localparam int B_LSB    = TILE * A_W;
    localparam int ROWS_LSB = 2 * TILE * A_W;
    localparam int COLS_LSB = ROWS_LSB + SIZE_W;
    localparam int IN_BITS  = COLS_LSB + SIZE_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;

    // Per-cycle controls broadcast from the top level to every cell.
    typedef struct packed {
        logic load;   // input transfer: capture products
        logic step;   // product stage advances into the accumulators
        logic snap;   // end of inner dimension: copy sums into the drain chain
        logic shift;  // drain chain moves one place towards the head
    } tma_ctrl_t;

    // Bookkeeping that travels with each sum along the drain chain.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tma_hold_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] raw);
        if (raw > SIZE_W'(TILE))
            return SIZE_W'(TILE);
        else
            return raw;
    endfunction

endpackage

>>> sv/tma_cell.sv
// One accumulator cell of the tile: product register, saturating accumulator and
// one place of the drain chain. Depends on tma_pkg.
module tma_cell
    import tma_pkg::*;
#(
    parameter int ROW       = 0,
    parameter int COL       = 0,
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tma_ctrl_t                   ctrl,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [A_W-1:0]       b,
    input  logic        [SIZE_W-1:0]    rows,
    input  logic        [SIZE_W-1:0]    cols,
    input  tma_hold_t                   next_info,
    input  logic        [ACC_WIDTH-1:0] next_value,
    output tma_hold_t                   info,
    output logic        [ACC_WIDTH-1:0] value
);

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [ACC_WIDTH-1:0] acc_next;
    tma_hold_t                   info_reg;
    tma_hold_t                   info_next;
    logic        [ACC_WIDTH-1:0] value_reg;
    logic        [ACC_WIDTH-1:0] value_next;

    logic                        active;
    logic                        is_last;
    logic signed [PROD_W-1:0]    addend;
    logic signed [ACC_WIDTH:0]   sum;
    logic signed [ACC_WIDTH-1:0] sat_sum;

    assign active  = (SIZE_W'(ROW) < rows) && (SIZE_W'(COL) < cols);
    assign is_last = (SIZE_W'(ROW + 1) == rows) && (SIZE_W'(COL + 1) == cols);
    assign addend  = active ? prod_reg : '0;

    // The exact sum always fits one bit wider; differing top bits mean overflow.
    always_comb
    begin
        sum = (ACC_WIDTH+1)'(acc_reg) + (ACC_WIDTH+1)'(addend);
        if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1])
            sat_sum = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        else
            sat_sum = sum[ACC_WIDTH-1:0];
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.step)
            acc_next = ctrl.snap ? '0 : sat_sum;
    end

    always_comb
    begin
        info_next  = info_reg;
        value_next = value_reg;
        if (ctrl.snap)
        begin
            info_next.valid = active;
            info_next.last  = active && is_last;
            info_next.row   = IDX_W'(ROW);
            info_next.col   = IDX_W'(COL);
            value_next      = sat_sum;
        end
        else if (ctrl.shift)
        begin
            info_next  = next_info;
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            info_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            info_reg <= info_next;
        end
    end

    assign info  = info_reg;
    assign value = value_reg;

endmodule

>>> sv/tile_matmul_accumulator_core.sv
// Top level of the 4x4 outer-product tile accumulator: stream ports, product stage
// control, the row of sixteen cells and the output register. Depends on tma_pkg, tma_cell.
//
// The block takes one inner-index step per cycle while s_tready is high: four signed
// Q8.8 A values and four B values, whose sixteen products are registered in the cells
// and then added into saturating Q32.16 accumulators (default width). The transfer
// that carries tlast (end of the inner dimension) copies the valid_rows x valid_cols
// sums into a drain chain that runs through the cells towards cell zero, clears the
// accumulators, and the sums leave in row-major order with tlast on the final one;
// sizes above four count as four, and a size of zero gives no results. The first
// result goes through the product stage, the drain chain head and the output register
// to the master side. A drain visits each chain position up to its last valid sum
// (unused column positions between rows included), held by any master-side stall.
// Non-final steps keep flowing at one per cycle during a drain; a second final step
// waits in the product stage, holding the input, until the previous tile has drained.
module tile_matmul_accumulator_core
    import tma_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // a_row0, a_row1, a_row2, a_row3, b_col0, b_col1, b_col2, b_col3,
    // valid_rows, valid_cols, zero padding
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tlast,   // end_of_k
    output logic             m_tvalid,
    input  logic             m_tready,
    // out_row, out_col, sum_value, zero padding
    output logic [((2*IDX_W+ACC_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic             m_tlast    // last_of_tile
);

    localparam int OUT_W = ((2 * IDX_W + ACC_WIDTH + 7) / 8) * 8;

    logic signed [A_W-1:0]    a_in [TILE];
    logic signed [A_W-1:0]    b_in [TILE];
    logic        [SIZE_W-1:0] rows_in;
    logic        [SIZE_W-1:0] cols_in;

    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_eok_reg, s1_eok_next;
    logic        [SIZE_W-1:0] s1_rows_reg, s1_rows_next;
    logic        [SIZE_W-1:0] s1_cols_reg, s1_cols_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic                     m_tlast_reg, m_tlast_next;
    logic        [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    tma_hold_t                chain_info  [CELLS+1];
    logic        [ACC_WIDTH-1:0] chain_value [CELLS+1];
    logic        [CELLS-1:0]  busy_vec;
    logic                     chain_busy;
    logic                     advance;
    logic                     accept;
    logic                     out_load;
    tma_ctrl_t                ctrl;

    genvar gi, gr, gc;

    generate
        for (gi = 0; gi < TILE; gi++)
        begin : g_unpack
            assign a_in[gi] = s_tdata[A_LSB + gi*A_W +: A_W];
            assign b_in[gi] = s_tdata[B_LSB + gi*A_W +: A_W];
        end
    endgenerate

    assign rows_in = clamp_size(s_tdata[ROWS_LSB +: SIZE_W]);
    assign cols_in = clamp_size(s_tdata[COLS_LSB +: SIZE_W]);

    always_comb
    begin
        for (int k = 0; k < CELLS; k++)
            busy_vec[k] = chain_info[k].valid;
    end

    assign chain_busy = |busy_vec;

    // A final step may only reach the accumulators once the drain chain is empty.
    assign advance  = !(s1_valid_reg && s1_eok_reg && chain_busy);
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign out_load = !m_tvalid_reg || m_tready;

    always_comb
    begin
        ctrl.load  = accept;
        ctrl.step  = s1_valid_reg && advance;
        ctrl.snap  = s1_valid_reg && advance && s1_eok_reg;
        // An empty place at the head is dropped without waiting for the sink.
        ctrl.shift = chain_info[0].valid ? out_load : 1'b1;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_eok_next   = s1_eok_reg;
        s1_rows_next  = s1_rows_reg;
        s1_cols_next  = s1_cols_reg;
        if (advance)
        begin
            s1_valid_next = accept;
            if (accept)
            begin
                s1_eok_next  = s_tlast;
                s1_rows_next = rows_in;
                s1_cols_next = cols_in;
            end
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tlast_next  = m_tlast_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load)
        begin
            m_tvalid_next = chain_info[0].valid;
            m_tlast_next  = chain_info[0].last;
            m_tdata_next  = OUT_W'({chain_value[0], chain_info[0].col, chain_info[0].row});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_eok_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_eok_reg   <= s1_eok_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_rows_reg <= s1_rows_next;
        s1_cols_reg <= s1_cols_next;
        m_tlast_reg <= m_tlast_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign chain_info[CELLS]  = '0;
    assign chain_value[CELLS] = '0;

    generate
        for (gr = 0; gr < TILE; gr++)
        begin : g_row
            for (gc = 0; gc < TILE; gc++)
            begin : g_col
                tma_cell #(
                    .ROW       (gr),
                    .COL       (gc),
                    .ACC_WIDTH (ACC_WIDTH)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .a          (a_in[gr]),
                    .b          (b_in[gc]),
                    .rows       (s1_rows_reg),
                    .cols       (s1_cols_reg),
                    .next_info  (chain_info[gr*TILE + gc + 1]),
                    .next_value (chain_value[gr*TILE + gc + 1]),
                    .info       (chain_info[gr*TILE + gc]),
                    .value      (chain_value[gr*TILE + gc])
                );
            end
        end
    endgenerate

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sv/tma_checker.sv
// Port-level checks for the tile accumulator, bound to the top level.
// Depends on tma_pkg and tile_matmul_accumulator_core.
module tma_checker
    import tma_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tlast,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [((2*IDX_W+ACC_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic             m_tlast
);

    // Tiles accepted with a non-empty size that have not yet sent their final result.
    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       tile_in;
    logic       tile_out;

    assign tile_in  = s_tvalid && s_tready && s_tlast &&
                      (s_tdata[ROWS_LSB +: SIZE_W] != '0) &&
                      (s_tdata[COLS_LSB +: SIZE_W] != '0);
    assign tile_out = m_tvalid && m_tready && m_tlast;

    always_comb
    begin
        pending_next = pending_reg + 4'(tile_in) - 4'(tile_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("master payload changed during a stall");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result offered while in reset");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 4'd0)
        else $error("result offered with no tile outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd3)
        else $error("more tiles outstanding than the pipeline can hold");

endmodule

bind tile_matmul_accumulator_core tma_checker #(
    .ACC_WIDTH (ACC_WIDTH)
) u_tma_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> sim/tile_matmul_accumulator_core_tb.sv
// Self-checking testbench for the 4x4 outer-product tile accumulator core.
// It drives inner-index steps, predicts every tile sum, and checks each result transfer.
// Depends on tma_pkg and tile_matmul_accumulator_core.
module tile_matmul_accumulator_core_tb;

    import tma_pkg::*;

    localparam int  SUM_W       = ACC_WIDTH_DEF;
    localparam int  OUT_W       = ((2 * IDX_W + SUM_W + 7) / 8) * 8;
    localparam int  SUM_LSB     = 2 * IDX_W;
    localparam longint SUM_MAX  = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_MIN  = -SUM_MAX - 1;
    localparam int  RAND_STEPS  = 460;
    localparam int  DRAIN_WAIT  = 40;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [TILE-1:0][A_W-1:0] a;
        logic [TILE-1:0][A_W-1:0] b;
        logic [SIZE_W-1:0]        rows;
        logic [SIZE_W-1:0]        cols;
        logic                     eok;
        logic                     typed;
        longint                   typed_sum;
    } kstep_t;

    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        longint           sum;
        logic             last;
    } tile_sum_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;

    longint            tile_acc [CELLS];
    tile_sum_t         pending_sums [$];
    kstep_t            step_table [$];
    int                errors;
    int                steps_sent;
    int                tiles_closed;
    int                sums_seen;
    int                send_burst;
    int                recv_burst;
    longint            cycle_count;

    tile_matmul_accumulator_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag_mismatch(input string field, input longint got, input longint want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 field, sums_seen, got, want);
        errors++;
    endtask

    // Gap before the next transfer; a burst counter gives stretches with no idling.
    function automatic int next_gap(ref int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
            burst = $urandom_range(8, 40);
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [A_W-1:0] pick_q88();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return A_W'($urandom_range(0, 1023) - 512);
            default: return A_W'($urandom);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_W'($urandom_range(5, 7));
            default: return SIZE_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic kstep_t make_step(input int a0, a1, a2, a3, b0, b1, b2, b3,
                                         input int rows, cols, input bit eok,
                                         input bit typed, input longint typed_sum);
        kstep_t st;
        st.a         = {A_W'(a3), A_W'(a2), A_W'(a1), A_W'(a0)};
        st.b         = {A_W'(b3), A_W'(b2), A_W'(b1), A_W'(b0)};
        st.rows      = SIZE_W'(rows);
        st.cols      = SIZE_W'(cols);
        st.eok       = eok;
        st.typed     = typed;
        st.typed_sum = typed_sum;
        return st;
    endfunction

    // Adds the outer product of one accepted step into the tile and, at the end of
    // the inner dimension, queues the tile sums in row-major order and clears them.
    task automatic fold_outer_product(input kstep_t st);
        int        nr;
        int        nc;
        longint    prod;
        longint    total;
        tile_sum_t rec;
        nr = (st.rows > SIZE_W'(TILE)) ? TILE : int'(st.rows);
        nc = (st.cols > SIZE_W'(TILE)) ? TILE : int'(st.cols);
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                prod  = longint'($signed(st.a[i])) * longint'($signed(st.b[j]));
                total = tile_acc[i * TILE + j] + prod;
                if (total > SUM_MAX)
                    total = SUM_MAX;
                else if (total < SUM_MIN)
                    total = SUM_MIN;
                tile_acc[i * TILE + j] = total;
            end
        end
        if (st.eok)
        begin
            for (int i = 0; i < nr; i++)
            begin
                for (int j = 0; j < nc; j++)
                begin
                    rec.row  = IDX_W'(i);
                    rec.col  = IDX_W'(j);
                    rec.sum  = st.typed ? st.typed_sum : tile_acc[i * TILE + j];
                    rec.last = (i == nr - 1) && (j == nc - 1);
                    pending_sums.push_back(rec);
                end
            end
            foreach (tile_acc[k])
                tile_acc[k] = 0;
            tiles_closed++;
        end
    endtask

    task automatic send_step(input kstep_t st, input int gap);
        logic [IN_W-1:0] word;
        word = '0;
        for (int i = 0; i < TILE; i++)
        begin
            word[A_LSB + i * A_W +: A_W] = st.a[i];
            word[B_LSB + i * A_W +: A_W] = st.b[i];
        end
        word[ROWS_LSB +: SIZE_W] = st.rows;
        word[COLS_LSB +: SIZE_W] = st.cols;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= st.eok;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        fold_outer_product(st);
        steps_sent++;
    endtask

    task automatic build_directed();
        // After reset a zero step must give sixteen zero sums.
        step_table.push_back(make_step(0, 0, 0, 0, 0, 0, 0, 0, 4, 4, 1, 1, 0));
        step_table.push_back(make_step(-32768, 0, 0, 0, -32768, 0, 0, 0, 1, 1, 1, 1,
                                       1073741824));
        step_table.push_back(make_step(32767, 32767, 32767, 32767,
                                       -32768, -32768, -32768, -32768, 4, 4, 1, 1,
                                       -1073709056));
        step_table.push_back(make_step(32767, 32767, 32767, 32767,
                                       32767, 32767, 32767, 32767, 2, 3, 1, 1,
                                       1073676289));
        step_table.push_back(make_step(-32768, -32768, -32768, -32768,
                                       32767, 32767, 32767, 32767, 4, 1, 1, 1,
                                       -1073709056));
        // Zero rows at the end of a tile: nothing is emitted.
        step_table.push_back(make_step(100, 200, 300, 400, 5, 6, 7, 8, 0, 4, 1, 0, 0));
        // Zero columns adds nothing, so the following tile sums to zero.
        step_table.push_back(make_step(100, 200, 300, 400, 5, 6, 7, 8, 4, 0, 0, 0, 0));
        step_table.push_back(make_step(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 0));
        // A zero-sized final step still clears what was gathered before it.
        step_table.push_back(make_step(256, 256, 256, 256, 256, 256, 256, 256, 4, 4, 0, 0, 0));
        step_table.push_back(make_step(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        step_table.push_back(make_step(0, 0, 0, 0, 0, 0, 0, 0, 4, 4, 1, 1, 0));
        // Sizes changing inside one tile.
        step_table.push_back(make_step(256, -256, 128, -1, 256, 512, -32768, 1, 4, 4, 0, 0, 0));
        step_table.push_back(make_step(256, -256, 128, -1, 256, 512, -32768, 1, 2, 2, 0, 0, 0));
        step_table.push_back(make_step(-1, 2, 3, -4, 5, -6, 7, -8, 3, 1, 1, 0, 0));
        // Oversized counts are taken as a full tile.
        step_table.push_back(make_step(1000, -2000, 3000, -4000, 7, 6, 5, 4, 7, 5, 0, 0, 0));
        step_table.push_back(make_step(-9, 8, -7, 6, 1234, -4321, 32767, -32768, 6, 4,
                                       1, 0, 0));
        step_table.push_back(make_step(32767, 32767, 32767, 32767, -1, -1, -1, -1, 1, 4,
                                       1, 0, 0));
        step_table.push_back(make_step(-1, -1, -1, -1, -1, -1, -1, -1, 4, 4, 1, 1, 1));
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d sums pending",
                     cycle_count, pending_sums.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: checks every transfer against the oldest pending sum.
    always @(posedge clk)
    begin
        tile_sum_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_sums.size() == 0)
                flag_mismatch("result with no sum pending", longint'($signed(
                              m_tdata[SUM_LSB +: SUM_W])), 0);
            else
            begin
                want = pending_sums.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.row)
                    flag_mismatch("out_row", m_tdata[IDX_W-1:0], want.row);
                if (m_tdata[IDX_W +: IDX_W] !== want.col)
                    flag_mismatch("out_col", m_tdata[IDX_W +: IDX_W], want.col);
                if (longint'($signed(m_tdata[SUM_LSB +: SUM_W])) !== want.sum)
                    flag_mismatch("sum_value", longint'($signed(m_tdata[SUM_LSB +: SUM_W])),
                                  want.sum);
                if (m_tlast !== want.last)
                    flag_mismatch("last_of_tile", m_tlast, want.last);
            end
            sums_seen++;
        end
    end

    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = next_gap(recv_burst);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
        end
    end

    initial
    begin
        kstep_t            st;
        int                run_len;
        logic [SIZE_W-1:0] run_rows;
        logic [SIZE_W-1:0] run_cols;
        int                rand_steps;
        errors       = 0;
        steps_sent   = 0;
        tiles_closed = 0;
        sums_seen    = 0;
        send_burst   = 0;
        recv_burst   = 0;
        cycle_count  = 0;
        rand_steps   = 0;
        foreach (tile_acc[k])
            tile_acc[k] = 0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        rst_n    <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_directed();
        foreach (step_table[k])
            send_step(step_table[k], next_gap(send_burst));

        // Mostly well-formed tiles of random length and content; now and then a
        // step changes size or carries an out-of-range count.
        while (rand_steps < RAND_STEPS)
        begin
            run_len  = $urandom_range(1, 8);
            run_rows = pick_size();
            run_cols = pick_size();
            for (int s = 0; s < run_len; s++)
            begin
                for (int i = 0; i < TILE; i++)
                begin
                    st.a[i] = pick_q88();
                    st.b[i] = pick_q88();
                end
                st.rows      = ($urandom_range(0, 7) == 0) ? SIZE_W'($urandom) : run_rows;
                st.cols      = ($urandom_range(0, 7) == 0) ? SIZE_W'($urandom) : run_cols;
                st.eok       = (s == run_len - 1) || ($urandom_range(0, 19) == 0);
                st.typed     = 1'b0;
                st.typed_sum = 0;
                send_step(st, next_gap(send_burst));
                rand_steps++;
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d inner-index steps closing %0d tiles; %0d tile sums checked.",
                 steps_sent, tiles_closed, sums_seen);
        $display("Covered extreme operands, zero and oversized tile shapes, size changes "
                 , "within a tile, and random idling on both sides.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> tile_matmul_accumulator_core.f
sv/tma_pkg.sv
sv/tma_cell.sv
sv/tile_matmul_accumulator_core.sv
sv/tma_checker.sv
sim/tile_matmul_accumulator_core_tb.sv
